@@ src/cubic_hermite_segment_eval_defines.svh @@
// assertion macros for the segment evaluator
`ifndef CUBIC_HERMITE_SEGMENT_EVAL_DEFINES_SVH
`define CUBIC_HERMITE_SEGMENT_EVAL_DEFINES_SVH

// property checked on the rising edge, quiet while reset is held
`define CHSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising edge, reset included
`define CHSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/chse_pkg.sv @@
package chse_pkg;

  localparam int unsigned NUM_W   = 96;  // signed numerator width
  localparam int unsigned DEN_W   = 51;  // magnitude of d cubed
  localparam int unsigned REM_W   = NUM_W + 2;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned DIV_LAT = Q_W + 3;
  localparam int unsigned FRONT_STAGES = 8;

  typedef enum logic [2:0] {
    REG_X_START     = 3'd0,
    REG_Y_START     = 3'd1,
    REG_SLOPE_START = 3'd2,
    REG_X_END       = 3'd3,
    REG_Y_END       = 3'd4,
    REG_SLOPE_END   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  typedef struct packed {
    logic          sat;
    logic [Q_W-1:0] value;
  } div_res_t;

endpackage

@@ src/cubic_hermite_segment_eval.sv @@
// cubic hermite segment evaluator
// six apb registers (byte address 4*i) hold x_start, y_start, slope_start,
// x_end, y_end and slope_end in signed q8.8; reads return them zero-extended
// slave stream: tdata carries x_query (q8.8), one transfer per query
// master stream: tdata carries y_value, first_derivative, second_derivative
// (q16.16, rounded to nearest, ties away from zero, clamped), tuser the status
// status: ok, saturated (some field clamped) or degenerate (x_end = x_start,
// all fields zero)
// the pipe has 8 front stages for the polynomial and 35 for the rounding
// dividers, then the output register that drives the master side
// throughput: one query per cycle while the output is not stalled; the
// dividers are pipelined, one quotient bit per stage, three lanes in parallel
// reset clears the registers to the unit interval with a flat curve and
// empties the pipeline
// when the receiver stalls, the pipe keeps moving until a result reaches the
// last stage; only then does tready drop, nothing is lost or repeated
// registers must be written only while no query is in flight; the block does not enforce it
module cubic_hermite_segment_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] x_query
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] y_value, [63:32] first, [95:64] second
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import chse_pkg::*;

  localparam int unsigned NST = FRONT_STAGES + DIV_LAT;

  // configuration registers
  logic signed [15:0] x0_q, y0_q, s0_q, x1_q, y1_q, s1_q;
  logic               wr;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= '0;
      y0_q <= '0;
      s0_q <= '0;
      x1_q <= 16'sd256;
      y1_q <= '0;
      s1_q <= '0;
    end else if (wr) begin
      unique case (reg_idx_e'(idx))
        REG_X_START:     x0_q <= pwdata[15:0];
        REG_Y_START:     y0_q <= pwdata[15:0];
        REG_SLOPE_START: s0_q <= pwdata[15:0];
        REG_X_END:       x1_q <= pwdata[15:0];
        REG_Y_END:       y1_q <= pwdata[15:0];
        REG_SLOPE_END:   s1_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(idx))
      REG_X_START:     prdata = {16'd0, x0_q};
      REG_Y_START:     prdata = {16'd0, y0_q};
      REG_SLOPE_START: prdata = {16'd0, s0_q};
      REG_X_END:       prdata = {16'd0, x1_q};
      REG_Y_END:       prdata = {16'd0, y1_q};
      REG_SLOPE_END:   prdata = {16'd0, s1_q};
      default:         prdata = '0;
    endcase
  end

  // coefficient chain, free running; after a write each level settles before
  // any query can reach the stage that reads it
  logic signed [16:0] dlt_q, ddy_q, ssum_q, d2_q;
  logic signed [17:0] s2sum_q;
  logic               degen_q;
  logic signed [33:0] dsq_q;
  logic signed [35:0] a_q;
  logic signed [36:0] b_q;
  logic signed [50:0] d3_q;
  logic signed [53:0] bd_q;
  logic signed [66:0] cdd_q, y0d3_q;
  logic [DEN_W-1:0]   den_q;
  logic               dneg_q;

  logic signed [33:0] sd_prod, dsq_d;
  logic signed [35:0] s2d_prod;
  logic signed [50:0] d3_d;
  logic signed [53:0] bd_d;
  logic signed [66:0] cdd_d, y0d3_d;

  assign sd_prod  = ssum_q * dlt_q;
  assign s2d_prod = s2sum_q * dlt_q;
  assign dsq_d    = dlt_q * dlt_q;
  assign d3_d     = dsq_q * d2_q;
  assign bd_d     = b_q * d2_q;
  assign cdd_d    = s0_q * d3_q;
  assign y0d3_d   = y0_q * d3_q;

  always_ff @(posedge clk_i) begin
    dlt_q   <= 17'(x1_q) - 17'(x0_q);
    ddy_q   <= 17'(y1_q) - 17'(y0_q);
    ssum_q  <= 17'(s0_q) + 17'(s1_q);
    s2sum_q <= (18'(s0_q) <<< 1) + 18'(s1_q);
    degen_q <= (x1_q == x0_q);
    // a = (s0+s1)*d - 512*dy, b = 768*dy - (2*s0+s1)*d
    dsq_q   <= dsq_d;
    a_q     <= 36'(sd_prod) - (36'(ddy_q) <<< 9);
    b_q     <= (37'(ddy_q) <<< 9) + (37'(ddy_q) <<< 8) - 37'(s2d_prod);
    d2_q    <= dlt_q;
    d3_q    <= d3_d;
    bd_q    <= bd_d;
    cdd_q   <= cdd_d;
    y0d3_q  <= y0d3_d;
    dneg_q  <= d3_q[50];
    den_q   <= d3_q[50] ? DEN_W'(-d3_q) : DEN_W'(d3_q);
  end

  // pipeline control
  logic [NST-1:0] vld_q;
  logic           en;
  logic           out_valid_q;

  assign en            = !vld_q[NST-1] || !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // front stages: horner form in u = x_query - x_start
  logic signed [15:0] xq_q;
  logic signed [16:0] u2_q, u3_q, u4_q, u5_q, u6_q, u_d;
  logic signed [52:0] p_q, p_d;
  logic signed [55:0] e_q;
  logic signed [56:0] fir_q;
  logic signed [57:0] sec3_q, sec4_q, sec5_q, sec6_q;
  logic signed [72:0] f_q, f_d;
  logic signed [73:0] g_q, g_d, f2_q;
  logic signed [74:0] n1p5_q, n1p6_q;
  logic signed [53:0] hlo_q, hlo_d;
  logic signed [54:0] hhi_q, hhi_d;
  logic signed [NUM_W-1:0] ny_q, n1_q, n2_q;

  assign u_d   = 17'(xq_q) - 17'(x0_q);
  assign p_d   = a_q * u2_q;
  assign f_d   = e_q * u4_q;
  assign g_d   = fir_q * u4_q;
  assign hlo_d = $signed({1'b0, f2_q[35:0]}) * u6_q;
  assign hhi_d = $signed(f2_q[73:36]) * u6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xq_q   <= s_axis_tdata;
      u2_q   <= u_d;
      p_q    <= p_d;
      u3_q   <= u2_q;
      // y: a*u + b*d, y': 3a*u + 2b*d, y'': 6a*u + 2b*d
      e_q    <= 56'(p_q) + 56'(bd_q);
      fir_q  <= (57'(p_q) <<< 1) + 57'(p_q) + (57'(bd_q) <<< 1);
      sec3_q <= (58'(p_q) <<< 2) + (58'(p_q) <<< 1) + (58'(bd_q) <<< 1);
      u4_q   <= u3_q;
      f_q    <= f_d;
      g_q    <= g_d;
      sec4_q <= sec3_q;
      u5_q   <= u4_q;
      f2_q   <= 74'(f_q) + 74'(cdd_q);
      n1p5_q <= 75'(g_q) + 75'(cdd_q);
      sec5_q <= sec4_q;
      u6_q   <= u5_q;
      // last multiply split into the low 36 and high 38 bits of the 74-bit operand
      hlo_q  <= hlo_d;
      hhi_q  <= hhi_d;
      n1p6_q <= n1p5_q;
      sec6_q <= sec5_q;
      ny_q   <= (NUM_W'(hhi_q) <<< 36) + NUM_W'(hlo_q) + (NUM_W'(y0d3_q) <<< 8);
      n1_q   <= NUM_W'(n1p6_q) <<< 8;
      n2_q   <= NUM_W'(sec6_q) <<< 16;
    end
  end

  // rounding dividers, one lane per output
  div_res_t res_y, res_1, res_2;

  chse_div u_div_y (
    .clk_i, .en_i(en), .num_i(ny_q), .den_i(den_q), .den_neg_i(dneg_q), .res_o(res_y)
  );
  chse_div u_div_1 (
    .clk_i, .en_i(en), .num_i(n1_q), .den_i(den_q), .den_neg_i(dneg_q), .res_o(res_1)
  );
  chse_div u_div_2 (
    .clk_i, .en_i(en), .num_i(n2_q), .den_i(den_q), .den_neg_i(dneg_q), .res_o(res_2)
  );

  // output register
  logic [95:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && vld_q[NST-1]) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      if (degen_q) begin
        out_data_q <= '0;
        out_user_q <= ST_DEGEN;
      end else begin
        out_data_q <= {res_2.value, res_1.value, res_y.value};
        out_user_q <= (res_y.sat | res_1.sat | res_2.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ src/chse_div.sv @@
module chse_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [chse_pkg::NUM_W-1:0] num_i,
  input  logic [chse_pkg::DEN_W-1:0]      den_i,
  input  logic                            den_neg_i,
  output chse_pkg::div_res_t              res_o
);
  import chse_pkg::*;

  // stage a: sign and magnitude
  logic             neg_a_q;
  logic [NUM_W-1:0] mag_a_q;
  // stage b: 2*|n| + den, so the floor gives the rounded quotient
  logic             neg_b_q;
  logic [REM_W-1:0] m2_b_q;
  // limits for clamping; den must only move while idle, not enforced here
  logic [REM_W-1:0] lim_pos_q, lim_neg_q;

  logic [REM_W-1:0] rem_q [0:Q_W];
  logic [Q_W-1:0]   quo_q [0:Q_W];
  logic             neg_q [0:Q_W];
  logic             sat_q [0:Q_W];

  always_ff @(posedge clk_i) begin
    lim_pos_q <= REM_W'(den_i) << Q_W;
    lim_neg_q <= (REM_W'(den_i) << Q_W) + (REM_W'(den_i) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= num_i[NUM_W-1] ^ den_neg_i;
      mag_a_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      neg_b_q <= neg_a_q;
      m2_b_q  <= (REM_W'(mag_a_q) << 1) + REM_W'(den_i);
      neg_q[0] <= neg_b_q;
      sat_q[0] <= neg_b_q ? (m2_b_q >= lim_neg_q) : (m2_b_q >= lim_pos_q);
      rem_q[0] <= m2_b_q;
      quo_q[0] <= '0;
    end
  end

  // one quotient bit per stage against 2*den shifted into place
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [REM_W-1:0] dv;
    logic             ge;
    assign dv = REM_W'({den_i, 1'b0}) << (Q_W - 1 - k);
    assign ge = rem_q[k] >= dv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - dv : rem_q[k];
        quo_q[k+1] <= quo_q[k] | (Q_W'(ge) << (Q_W - 1 - k));
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  always_comb begin
    res_o.sat = sat_q[Q_W];
    if (sat_q[Q_W]) begin
      res_o.value = neg_q[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      res_o.value = neg_q[Q_W] ? Q_W'(-quo_q[Q_W]) : quo_q[Q_W];
    end
  end

endmodule

@@ src/chse_checker.sv @@
`include "cubic_hermite_segment_eval_defines.svh"

module chse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import chse_pkg::*;

  // a stalled result holds its payload
  `CHSE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // input is refused only behind a waiting result
  `CHSE_ASSERT(a_ready_cause, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

  // degenerate interval gives all-zero fields
  `CHSE_ASSERT(a_degen_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_DEGEN |-> m_axis_tdata == '0, "degenerate result not zero")

  // no result straight out of reset
  `CHSE_ASSERT_ALWAYS(a_reset_empty, clk_i, $rose(rst_ni) |-> !m_axis_tvalid, "result valid after reset")

endmodule

bind cubic_hermite_segment_eval chse_checker u_chse_checker (.*);

@@ bench/tb_cubic_hermite_segment_eval.sv @@
`timescale 1ns / 1ps

module tb_cubic_hermite_segment_eval;
  import chse_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned NUM_RANDOM   = 700;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [2:0]  UNUSED_IDX_A = 3'd6;    // decoded as nothing
  localparam logic [2:0]  UNUSED_IDX_B = 3'd7;

  typedef struct {
    logic [31:0] y_value;
    logic [31:0] first_deriv;
    logic [31:0] second_deriv;
    status_e     status;
  } curve_point_t;

  // one directed row: configuration set, query, and a typed result where obvious
  typedef struct {
    int           cfg_set;
    logic [15:0]  x_query;
    bit           known;
    curve_point_t result;
  } query_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] x_query
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // [31:0] y_value, [63:32] first, [95:64] second
  logic [1:0]  m_axis_tuser;   // [1:0] status

  cubic_hermite_segment_eval u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the six curve registers
  logic [15:0]  curve_regs [6];
  curve_point_t pending_points [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_left;
  bit           row_known;
  curve_point_t row_result;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // round num/den to nearest, ties away from zero, clamp to signed 32 bits
  function automatic logic [31:0] round_clamp(input logic signed [127:0] num,
                                              input logic signed [127:0] den,
                                              inout bit sat);
    logic signed [127:0] mag, quo, rem;
    mag = (num < 0) ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (rem >= den - rem) quo = quo + 1;
    if (num < 0) begin
      if (quo > 128'sh8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-quo);
    end
    if (quo > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return 32'(quo);
  endfunction

  // value and both derivatives of the configured cubic at one abscissa
  function automatic curve_point_t eval_curve(input logic [15:0] xq_raw);
    logic signed [127:0] x0, y0, s0, x1, y1, s1, xq;
    logic signed [127:0] d, u, dy, a, b, c, d3, ny, n1, n2;
    curve_point_t pt;
    bit sat;
    x0 = $signed(curve_regs[REG_X_START]);
    y0 = $signed(curve_regs[REG_Y_START]);
    s0 = $signed(curve_regs[REG_SLOPE_START]);
    x1 = $signed(curve_regs[REG_X_END]);
    y1 = $signed(curve_regs[REG_Y_END]);
    s1 = $signed(curve_regs[REG_SLOPE_END]);
    xq = $signed(xq_raw);
    sat = 1'b0;
    d  = x1 - x0;
    u  = xq - x0;
    dy = y1 - y0;
    if (d == 0) begin
      pt.y_value = '0;
      pt.first_deriv = '0;
      pt.second_deriv = '0;
      pt.status = ST_DEGEN;
      return pt;
    end
    a  = -512 * dy + (s0 + s1) * d;
    b  = 768 * dy - (2 * s0 + s1) * d;
    c  = s0 * d;
    d3 = d * d * d;
    ny = 256 * y0 * d3 + a * u * u * u + b * u * u * d + c * u * d * d;
    n1 = 256 * (3 * a * u * u + 2 * b * u * d + c * d * d);
    n2 = 65536 * (6 * a * u + 2 * b * d);
    // keep the denominator positive
    if (d < 0) begin
      ny = -ny;
      n1 = -n1;
      n2 = -n2;
      d3 = -d3;
    end
    pt.y_value      = round_clamp(ny, d3, sat);
    pt.first_deriv  = round_clamp(n1, d3, sat);
    pt.second_deriv = round_clamp(n2, d3, sat);
    pt.status       = sat ? ST_SAT : ST_OK;
    return pt;
  endfunction

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < 3'd6) curve_regs[idx] = value;
  endtask

  // only touch registers once the pipe has emptied
  task automatic wait_idle();
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_curve(input logic [15:0] xs, input logic [15:0] ys,
                            input logic [15:0] ss, input logic [15:0] xe,
                            input logic [15:0] ye, input logic [15:0] se);
    wait_idle();
    write_reg(REG_X_START, xs);
    write_reg(REG_Y_START, ys);
    write_reg(REG_SLOPE_START, ss);
    write_reg(REG_X_END, xe);
    write_reg(REG_Y_END, ye);
    write_reg(REG_SLOPE_END, se);
  endtask

  // offer one query and hold it until the transfer
  task automatic send_query(input logic [15:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk_i iff s_axis_tready);
  endtask

  // input transfer: queue up the expected point
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_points.push_back(row_known ? row_result : eval_curve(s_axis_tdata));
  end

  // output transfer: compare with the oldest expectation
  always @(posedge clk_i) begin
    curve_point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tdata[31:0] !== want.y_value)
          report_mismatch("y_value", m_axis_tdata[31:0], want.y_value);
        if (m_axis_tdata[63:32] !== want.first_deriv)
          report_mismatch("first_derivative", m_axis_tdata[63:32], want.first_deriv);
        if (m_axis_tdata[95:64] !== want.second_deriv)
          report_mismatch("second_derivative", m_axis_tdata[95:64], want.second_deriv);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
      end
    end
  end

  // receiver: random back-pressure, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    query_row_t   rows [$];
    curve_point_t zero_pt, degen_pt;
    int           cur_set;
    logic [15:0]  xs, xe, xq;

    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    error_count = 0; cycle_count = 0; hold_left = 0;
    send_idle_pct = 15; recv_idle_pct = 82;
    row_known = 1'b0;
    row_result = '{default: '0, status: ST_OK};
    curve_regs = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000};

    zero_pt  = '{y_value: '0, first_deriv: '0, second_deriv: '0, status: ST_OK};
    degen_pt = '{y_value: '0, first_deriv: '0, second_deriv: '0, status: ST_DEGEN};

    // set 0: reset curve is flat zero; set 1: degenerate interval
    // set 2: extremes of every register; set 3: unit step in x, steep slopes
    // set 4: reversed interval, negative span
    rows = '{
      '{0, 16'h0000, 1, zero_pt}, '{0, 16'h8000, 1, zero_pt},
      '{0, 16'h7FFF, 1, zero_pt}, '{0, 16'h0080, 1, zero_pt},
      '{1, 16'h1234, 1, degen_pt}, '{1, 16'h8000, 1, degen_pt},
      '{1, 16'h7FFF, 1, degen_pt},
      '{2, 16'h8000, 0, zero_pt}, '{2, 16'h7FFF, 0, zero_pt},
      '{2, 16'h0000, 0, zero_pt}, '{2, 16'hFFFF, 0, zero_pt},
      '{3, 16'h0000, 0, zero_pt}, '{3, 16'h0001, 0, zero_pt},
      '{3, 16'h7FFF, 0, zero_pt}, '{3, 16'h8000, 0, zero_pt},
      '{4, 16'h0080, 0, zero_pt}, '{4, 16'h0100, 0, zero_pt},
      '{4, 16'h0000, 0, zero_pt}, '{4, 16'hC000, 0, zero_pt}
    };

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    cur_set = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg_set != cur_set) begin
        s_axis_tvalid <= 1'b0;
        cur_set = rows[i].cfg_set;
        case (cur_set)
          1: load_curve(16'h1234, 16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h7FFF);
          2: load_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
          3: load_curve(16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h7FFF);
          default: load_curve(16'h0100, 16'h0200, 16'hFF00, 16'h0000, 16'hFE00, 16'h0300);
        endcase
      end
      row_known  = rows[i].known;
      row_result = rows[i].result;
      send_query(rows[i].x_query);
    end
    s_axis_tvalid <= 1'b0;
    row_known = 1'b0;

    // random part: a fresh curve per phase, idling pattern by thirds
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES / 3) begin
        send_idle_pct = 82; recv_idle_pct = 15;
      end else if (p == 2 * NUM_PHASES / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      s_axis_tvalid <= 1'b0;
      wait_idle();
      // writes to the unused register slots must leave the curve alone
      write_reg(UNUSED_IDX_A, 16'($urandom));
      write_reg(UNUSED_IDX_B, 16'($urandom));
      xs = 16'($urandom);
      // mostly short spans, now and then anything at all
      case ($urandom_range(3))
        0: xe = 16'($urandom);
        1: xe = xs + 16'($urandom_range(1, 8));
        default: xe = xs + 16'($urandom_range(0, 1024)) - 16'd512;
      endcase
      if (p == 1) xe = xs;
      load_curve(xs, 16'($urandom), 16'($urandom), xe, 16'($urandom), 16'($urandom));
      for (int n = 0; n < NUM_RANDOM / NUM_PHASES; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == NUM_PHASES - 1 && n == 5) hold_left = HOLD_CYCLES;
        if ($urandom_range(1)) xq = 16'($urandom);
        else xq = xs + 16'($urandom_range(0, 16'(xe - xs)));
        send_query(xq);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
